@@ sv/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg - shared types and constants of the bicolor LED serializer
// Holds the channel count, word widths, opcode codes and the write request
// struct that runs from the scaling stage into the storage cells.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int CHANNELS   = 8;
    localparam int GRAY_BITS  = 12;
    localparam int WORD_COUNT = 2 * CHANNELS;
    // Word position counter width. Never below one bit.
    localparam int WP_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    // Width of the channel number on the request port.
    localparam int CH_IN_W    = 3;
    localparam int IDX_W      = (WP_W > CH_IN_W) ? WP_W : CH_IN_W;
    localparam int BIT_W      = $clog2(GRAY_BITS);

    typedef logic [GRAY_BITS-1:0] t_word;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [WP_W-1:0]      t_wpos;
    typedef logic [BIT_W-1:0]     t_bpos;

    localparam t_word FULL_SCALE = t_word'((1 << GRAY_BITS) - 1);
    localparam t_bpos BIT_TOP    = t_bpos'(GRAY_BITS - 1);
    localparam t_wpos WORD_LAST  = t_wpos'(WORD_COUNT - 1);

    typedef enum logic [1:0] {
        OP_SET_BIPOLAR = 2'd0,
        OP_SET_RAW     = 2'd1,
        OP_SHIFT       = 2'd2
    } t_opcode;

    // Write request for one channel: both colour words at once.
    typedef struct packed {
        logic  en;
        t_idx  channel;
        t_word red;
        t_word green;
    } t_wr_req;

endpackage

@@ sv/bls_scale.sv @@
// ----------------------------------------------------------------------------
// bls_scale - level scaling for set requests
// Turns a bipolar Q1.14 level or a pair of raw Q1.16 intensities into the
// 12-bit red and green words of one channel, with saturation.
// ----------------------------------------------------------------------------
module bls_scale
    import bls_pkg::*;
(
    input  logic                 i_accept,
    input  logic [1:0]           i_opcode,
    input  logic [CH_IN_W-1:0]   i_channel_index,
    input  logic signed [15:0]   i_bipolar_level,
    input  logic [16:0]          i_red_raw,
    input  logic [16:0]          i_green_raw,
    output t_wr_req              o_wr
);

    logic signed [16:0] lev_x;
    logic        [16:0] lev_mag;
    logic               lev_neg;
    logic               lev_sat;
    logic        [25:0] lev_prod;
    t_word              lev_val;
    logic        [28:0] red_prod;
    logic        [28:0] green_prod;
    t_word              red_val;
    t_word              green_val;

    // Bipolar path: magnitude times 4095, then drop 14 bits.
    assign lev_x    = 17'(i_bipolar_level);
    assign lev_neg  = i_bipolar_level[15];
    assign lev_mag  = lev_neg ? 17'(-lev_x) : 17'(lev_x);
    assign lev_sat  = (lev_mag >= 17'd16384);
    assign lev_prod = 26'(lev_mag[13:0]) * 26'(FULL_SCALE);
    assign lev_val  = lev_sat ? FULL_SCALE : lev_prod[25:14];

    // Raw path: times 4095, drop 16 bits, clamp at full scale.
    assign red_prod   = 29'(i_red_raw) * 29'(FULL_SCALE);
    assign green_prod = 29'(i_green_raw) * 29'(FULL_SCALE);
    assign red_val    = red_prod[28] ? FULL_SCALE : red_prod[27:16];
    assign green_val  = green_prod[28] ? FULL_SCALE : green_prod[27:16];

    always_comb begin
        o_wr.channel = t_idx'(i_channel_index);
        o_wr.en      = 1'b0;
        o_wr.red     = red_val;
        o_wr.green   = green_val;
        unique case (t_opcode'(i_opcode))
            OP_SET_BIPOLAR: begin
                o_wr.en    = i_accept;
                o_wr.red   = lev_neg ? lev_val : '0;
                o_wr.green = lev_neg ? '0 : lev_val;
            end
            OP_SET_RAW: begin
                o_wr.en = i_accept;
            end
            default: begin
                o_wr.en = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/bls_cell.sv @@
// ----------------------------------------------------------------------------
// bls_cell - storage cell for one bicolor channel
// Holds the red and green words of one channel and merges the word that the
// serializer points at into the read chain passed on to its neighbor.
// ----------------------------------------------------------------------------
module bls_cell
    import bls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_idx    i_cell_idx,
    input  t_wr_req i_wr,
    input  t_wpos   i_rd_pos,
    input  t_word   i_chain,
    output t_word   o_chain
);

    t_word r_red;
    t_word r_green;
    t_word n_red;
    t_word n_green;
    logic  wr_hit;
    logic  rd_hit;

    assign wr_hit = i_wr.en && (i_wr.channel == i_cell_idx);
    assign rd_hit = (t_idx'(i_rd_pos >> 1) == i_cell_idx);

    always_comb begin
        n_red   = wr_hit ? i_wr.red : r_red;
        n_green = wr_hit ? i_wr.green : r_green;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= '0;
            r_green <= '0;
        end else begin
            r_red   <= n_red;
            r_green <= n_green;
        end
    end

    // Even word positions are red, odd ones green.
    assign o_chain = i_chain | (rd_hit ? (i_rd_pos[0] ? r_green : r_red) : '0);

endmodule

@@ sv/bicolor_led_grayscale_serializer_core.sv @@
// ----------------------------------------------------------------------------
// bicolor_led_grayscale_serializer_core - grayscale store and serial shifter
// Keeps a red and a green 12-bit grayscale word per bicolor channel and
// shifts all words out one bit per shift request, with latch and blank flags.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+------------------------------------
//  request  | i_in_valid / o_in_ready   | i_opcode, i_channel_index,
//           |                           | i_bipolar_level, i_red_raw,
//           |                           | i_green_raw
//  result   | o_out_valid / i_out_ready | o_serial_bit, o_latch_pulse,
//           |                           | o_blank_level
//
// Requests are accepted back to back while o_in_ready is high. A set
// request writes its channel's two words at the accepting edge, so a
// later shift request that starts one of those words sees them. A shift
// request's result is registered into a two-entry output buffer: the
// request side stalls only when both entries hold results not yet taken.
// Reset is synchronous: all words clear to zero, the frame restarts at word
// zero, bit eleven, and blank is high until the first frame has gone out.
// ----------------------------------------------------------------------------
module bicolor_led_grayscale_serializer_core
    import bls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_opcode,
    input  logic [CH_IN_W-1:0]   i_channel_index,
    input  logic signed [15:0]   i_bipolar_level,
    input  logic [16:0]          i_red_raw,
    input  logic [16:0]          i_green_raw,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_serial_bit,
    output logic                 o_latch_pulse,
    output logic                 o_blank_level
);

    typedef struct packed {
        logic serial_bit;
        logic latch_pulse;
        logic blank_level;
    } t_result;

    logic    accept;
    logic    shift_req;
    t_wr_req wr;
    t_word   chain [CHANNELS+1];
    t_word   cur_word;
    t_result new_res;

    t_wpos   r_word_pos;
    t_wpos   n_word_pos;
    t_bpos   r_bit_pos;
    t_bpos   n_bit_pos;
    t_word   r_shift_word;
    t_word   n_shift_word;
    logic    r_first_done;
    logic    n_first_done;

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;

    // The request side is open as long as the skid entry is free.
    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign shift_req  = accept && (t_opcode'(i_opcode) == OP_SHIFT);

    bls_scale u_scale (
        .i_accept        (accept),
        .i_opcode        (i_opcode),
        .i_channel_index (i_channel_index),
        .i_bipolar_level (i_bipolar_level),
        .i_red_raw       (i_red_raw),
        .i_green_raw     (i_green_raw),
        .o_wr            (wr)
    );

    // Row of channel cells. The word at the current position is merged into
    // the chain as it passes each cell; the far end carries the read word.
    assign chain[0] = '0;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        bls_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (t_idx'(g)),
            .i_wr       (wr),
            .i_rd_pos   (r_word_pos),
            .i_chain    (chain[g]),
            .o_chain    (chain[g+1])
        );
    end

    // At the top bit of a word the fresh copy is taken from the cells;
    // lower bits come from the held copy, so later writes wait a frame.
    assign cur_word = (r_bit_pos == BIT_TOP) ? chain[CHANNELS] : r_shift_word;

    always_comb begin
        new_res.serial_bit  = cur_word[r_bit_pos];
        new_res.blank_level = !r_first_done;
        new_res.latch_pulse = 1'b0;
        n_word_pos          = r_word_pos;
        n_bit_pos           = r_bit_pos;
        n_shift_word        = r_shift_word;
        n_first_done        = r_first_done;
        if (shift_req) begin
            n_shift_word = cur_word;
            if (r_bit_pos == '0) begin
                n_bit_pos = BIT_TOP;
                if (r_word_pos == WORD_LAST) begin
                    n_word_pos          = '0;
                    new_res.latch_pulse = 1'b1;
                    n_first_done        = 1'b1;
                end else begin
                    n_word_pos = r_word_pos + t_wpos'(1);
                end
            end else begin
                n_bit_pos = r_bit_pos - t_bpos'(1);
            end
        end
    end

    // Output buffer: the main entry drives the ports, the skid entry
    // catches a result that arrives while the main entry is stalled.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_out_valid && i_out_ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = shift_req;
                n_out       = new_res;
            end
        end else if (!r_out_valid) begin
            n_out_valid = shift_req;
            n_out       = new_res;
        end else if (shift_req) begin
            n_skid_valid = 1'b1;
            n_skid       = new_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_pos   <= '0;
            r_bit_pos    <= BIT_TOP;
            r_shift_word <= '0;
            r_first_done <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_word_pos   <= n_word_pos;
            r_bit_pos    <= n_bit_pos;
            r_shift_word <= n_shift_word;
            r_first_done <= n_first_done;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid   = r_out_valid;
    assign o_serial_bit  = r_out.serial_bit;
    assign o_latch_pulse = r_out.latch_pulse;
    assign o_blank_level = r_out.blank_level;

endmodule

@@ sim/bls_serial_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bls_serial_checker - bit stream predictor and checker for the serializer
// Watches both handshakes of the serializer core and keeps its own copy of
// the grayscale words and the frame position. Each accepted shift request
// yields one expected tick, which is compared with the next accepted result.
// ----------------------------------------------------------------------------
module bls_serial_checker
    import bls_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [CH_IN_W-1:0] i_channel_index,
    input  logic signed [15:0] i_bipolar_level,
    input  logic [16:0]        i_red_raw,
    input  logic [16:0]        i_green_raw,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_serial_bit,
    input  logic               i_latch_pulse,
    input  logic               i_blank_level,
    output int                 o_mismatches,
    output int                 o_pending
);

    typedef struct packed {
        logic serial_bit;
        logic latch_pulse;
        logic blank_level;
    } t_tick;

    t_word gray_model [WORD_COUNT];
    t_wpos word_pos;
    t_bpos bit_pos;
    t_word shift_copy;
    logic  frame_seen;
    t_tick expected_ticks [$];
    int    mismatch_count = 0;

    // Q1.16 intensity times full scale, truncated, saturated at full scale.
    function automatic t_word raw_to_gray(input logic [16:0] raw);
        longint scaled;
        scaled = (longint'(raw) * 4095) >> 16;
        return (scaled > longint'(FULL_SCALE)) ? FULL_SCALE : t_word'(scaled);
    endfunction

    always @(posedge i_clk) begin
        t_tick got;
        t_tick want;
        int    level;
        int    mag;
        if (!i_rst_n) begin
            foreach (gray_model[k]) gray_model[k] = '0;
            word_pos   = '0;
            bit_pos    = BIT_TOP;
            shift_copy = '0;
            frame_seen = 1'b0;
            expected_ticks.delete();
        end else begin
            // Results are checked before this edge's request is predicted,
            // since a shift result never leaves in its own request's cycle.
            if (i_out_valid && i_out_ready) begin
                got = '{serial_bit: i_serial_bit, latch_pulse: i_latch_pulse,
                        blank_level: i_blank_level};
                if (expected_ticks.size() == 0) begin
                    $error("unexpected result: serial_bit=%0b latch_pulse=%0b blank_level=%0b",
                           got.serial_bit, got.latch_pulse, got.blank_level);
                    mismatch_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.serial_bit !== want.serial_bit) begin
                        $error("serial_bit mismatch: expected %0b, actual %0b",
                               want.serial_bit, got.serial_bit);
                        mismatch_count++;
                    end
                    if (got.latch_pulse !== want.latch_pulse) begin
                        $error("latch_pulse mismatch: expected %0b, actual %0b",
                               want.latch_pulse, got.latch_pulse);
                        mismatch_count++;
                    end
                    if (got.blank_level !== want.blank_level) begin
                        $error("blank_level mismatch: expected %0b, actual %0b",
                               want.blank_level, got.blank_level);
                        mismatch_count++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                case (i_opcode)
                    OP_SET_BIPOLAR: begin
                        if (i_channel_index < CHANNELS) begin
                            level = i_bipolar_level;
                            // Half scale or more in either direction saturates.
                            if (level > 0)
                                mag = (level < 16384) ? (level * 4095) >> 14 : 4095;
                            else
                                mag = (level > -16384) ? ((-level) * 4095) >> 14 : 4095;
                            gray_model[2*i_channel_index]   = (level > 0) ? '0 : t_word'(mag);
                            gray_model[2*i_channel_index+1] = (level > 0) ? t_word'(mag) : '0;
                        end
                    end
                    OP_SET_RAW: begin
                        if (i_channel_index < CHANNELS) begin
                            gray_model[2*i_channel_index]   = raw_to_gray(i_red_raw);
                            gray_model[2*i_channel_index+1] = raw_to_gray(i_green_raw);
                        end
                    end
                    OP_SHIFT: begin
                        // The word is captured as its first bit goes out.
                        if (bit_pos == BIT_TOP) shift_copy = gray_model[word_pos];
                        want.serial_bit  = shift_copy[bit_pos];
                        want.latch_pulse = 1'b0;
                        want.blank_level = !frame_seen;
                        if (bit_pos == '0) begin
                            bit_pos = BIT_TOP;
                            if (word_pos == WORD_LAST) begin
                                word_pos         = '0;
                                want.latch_pulse = 1'b1;
                                frame_seen       = 1'b1;
                            end else begin
                                word_pos++;
                            end
                        end else begin
                            bit_pos--;
                        end
                        expected_ticks.push_back(want);
                    end
                    default: begin
                        // The unused opcode leaves everything as it is.
                    end
                endcase
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_ticks.size();
    end

endmodule

@@ sim/tb_bicolor_led_grayscale_serializer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bicolor_led_grayscale_serializer_core - stimulus and verdict
// Drives set and shift requests into the serializer core under several
// idling mixes, holds the result side off once to fill the block, and
// lets a separate checker predict and compare every serial tick.
// ----------------------------------------------------------------------------
module tb_bicolor_led_grayscale_serializer_core;
    import bls_pkg::*;

    // Opcode three is not assigned; the block must ignore it.
    localparam logic [1:0] OPC_UNUSED = 2'd3;
    // Cycles the result side is held off in the pressure stretch.
    localparam int PRESSURE_HOLD = 300;
    // Cycles without any accepted request or result before the run is
    // declared hung. The pressure stretch is the longest legal quiet spell;
    // random stalls at a 66 percent rate end far sooner.
    localparam int QUIET_LIMIT = 2000;
    // Random requests per idling phase.
    localparam int PHASE_ITEMS = 304;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               in_valid        = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode          = '0;
    logic [CH_IN_W-1:0] channel_index   = '0;
    logic signed [15:0] bipolar_level   = '0;
    logic [16:0]        red_raw         = '0;
    logic [16:0]        green_raw       = '0;
    logic               out_valid;
    logic               out_ready       = 1'b0;
    logic               serial_bit;
    logic               latch_pulse;
    logic               blank_level;

    int   mismatches;
    int   pending_ticks;

    // Idling mix of the current phase, in percent of cycles.
    int   sender_idle_pct = 0;
    int   stall_pct       = 0;
    // Raised once by the stimulus to ask the result side for a long hold-off.
    logic pressure_req    = 1'b0;

    bicolor_led_grayscale_serializer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_channel_index (channel_index),
        .i_bipolar_level (bipolar_level),
        .i_red_raw       (red_raw),
        .i_green_raw     (green_raw),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_serial_bit    (serial_bit),
        .o_latch_pulse   (latch_pulse),
        .o_blank_level   (blank_level)
    );

    bls_serial_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_opcode        (opcode),
        .i_channel_index (channel_index),
        .i_bipolar_level (bipolar_level),
        .i_red_raw       (red_raw),
        .i_green_raw     (green_raw),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_serial_bit    (serial_bit),
        .i_latch_pulse   (latch_pulse),
        .i_blank_level   (blank_level),
        .o_mismatches    (mismatches),
        .o_pending       (pending_ticks)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Offers one request and returns at the edge that accepts it. It must
    // be called right after a rising edge. Valid is only lowered when the
    // sender decides to idle, so back-to-back requests keep it high.
    task automatic send_request(input logic [1:0] op, input logic [CH_IN_W-1:0] ch,
                                input logic signed [15:0] lvl,
                                input logic [16:0] red, input logic [16:0] green);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        channel_index <= ch;
        bipolar_level <= lvl;
        red_raw       <= red;
        green_raw     <= green;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // The fields a request does not use carry random junk.
    task automatic send_shift();
        send_request(OP_SHIFT, CH_IN_W'($urandom), 16'($urandom),
                     17'($urandom), 17'($urandom));
    endtask

    task automatic send_bipolar(input logic [CH_IN_W-1:0] ch, input logic signed [15:0] lvl);
        send_request(OP_SET_BIPOLAR, ch, lvl, 17'($urandom), 17'($urandom));
    endtask

    task automatic send_raw(input logic [CH_IN_W-1:0] ch, input logic [16:0] red,
                            input logic [16:0] green);
        send_request(OP_SET_RAW, ch, 16'($urandom), red, green);
    endtask

    // Raw intensities lean on the points around 0, 1.0 and the top of the
    // field, where truncation and saturation turn over.
    function automatic logic [16:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 17'd0;
            1:       return 17'd65535;
            2:       return 17'd65536;
            3:       return 17'($urandom_range(65537, 131071));
            4, 5:    return 17'($urandom_range(0, 65536));
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    task automatic send_random();
        int                 pick;
        logic signed [15:0] lvl;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            send_shift();
        end else if (pick < 72) begin
            case ($urandom_range(0, 9))
                0:       lvl = 16'sd32767;
                1:       lvl = 16'sd16384;
                2:       lvl = 16'sd16383;
                3:       lvl = 16'sd0;
                4:       lvl = 16'(-16384);
                5:       lvl = 16'(-16383);
                6:       lvl = 16'(-32768);
                default: lvl = 16'($urandom);
            endcase
            send_bipolar(CH_IN_W'($urandom), lvl);
        end else if (pick < 94) begin
            send_raw(CH_IN_W'($urandom), pick_raw(), pick_raw());
        end else begin
            send_request(OPC_UNUSED, CH_IN_W'($urandom), 16'($urandom),
                         17'($urandom), 17'($urandom));
        end
    endtask

    // Result side: random stalls at the phase's rate, plus one long hold-off
    // on request, counted here so the sender keeps offering meanwhile.
    initial begin
        int hold_left;
        bit pressure_taken;
        hold_left      = 0;
        pressure_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (pressure_req && !pressure_taken) begin
                pressure_taken = 1'b1;
                hold_left      = PRESSURE_HOLD - 1;
                out_ready     <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** bicolor_led_grayscale_serializer_core: FAILED **");
        $finish;
    end

    initial begin
        int idle_mix  [4];
        int stall_mix [4];
        idle_mix  = '{0, 66, 0, 37};
        stall_mix = '{0, 0, 66, 37};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bipolar extremes on every channel: full positive, the half scale
        // boundary from both sides, the smallest levels either way, and the
        // most negative level, which must saturate rather than wrap.
        send_bipolar(3'd0, 16'sd32767);
        send_bipolar(3'd1, 16'sd16384);
        send_bipolar(3'd2, 16'sd16383);
        send_bipolar(3'd3, 16'sd1);
        send_bipolar(3'd4, 16'(-1));
        send_bipolar(3'd5, 16'(-16383));
        send_bipolar(3'd6, 16'(-16384));
        send_bipolar(3'd7, 16'(-32768));
        // The unused opcode must neither write nor produce a result.
        send_request(OPC_UNUSED, 3'd0, 16'sd0, 17'd65536, 17'd65536);

        // One whole frame with blank still high. The result side holds off
        // for a long stretch here, so the block fills and stalls its input.
        pressure_req = 1'b1;
        repeat (WORD_COUNT * GRAY_BITS) send_shift();

        // Zero level, a negative level just past half scale, and raw values
        // at zero, at and around 1.0, and above 1.0 up to the field's top.
        send_bipolar(3'd0, 16'sd0);
        send_bipolar(3'd1, 16'(-16385));
        send_raw(3'd2, 17'd0, 17'd0);
        send_raw(3'd3, 17'd65536, 17'd65535);
        send_raw(3'd4, 17'd131071, 17'd1);
        send_raw(3'd5, 17'd1, 17'd65537);
        send_raw(3'd6, 17'd65535, 17'd0);
        send_raw(3'd7, 17'd0, 17'd131071);
        // Second frame, the first one with blank low.
        repeat (WORD_COUNT * GRAY_BITS) send_shift();

        // Random traffic under each idling mix in turn.
        foreach (idle_mix[p]) begin
            sender_idle_pct = idle_mix[p];
            stall_pct       = stall_mix[p];
            repeat (PHASE_ITEMS) send_random();
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_ticks != 0) @(posedge i_clk);
        // Keep the clock running so that a stray extra result would be seen.
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending_ticks == 0)
            $display("** bicolor_led_grayscale_serializer_core: PASSED **");
        else
            $display("** bicolor_led_grayscale_serializer_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/bls_pkg.sv
sv/bls_scale.sv
sv/bls_cell.sv
sv/bicolor_led_grayscale_serializer_core.sv
sim/bls_serial_checker.sv
sim/tb_bicolor_led_grayscale_serializer_core.sv
